// File: hw/rtl/lrd_pkg.sv
// Shared word types and result codes for the log record deframer.
`default_nettype none

package lrd_pkg;

  localparam logic [2:0] KIND_OP   = 3'd0;
  localparam logic [2:0] KIND_KLEN = 3'd1;
  localparam logic [2:0] KIND_KEY  = 3'd2;
  localparam logic [2:0] KIND_VLEN = 3'd3;
  localparam logic [2:0] KIND_VAL  = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;

  localparam logic [2:0] ERR_NO_OP     = 3'd0;
  localparam logic [2:0] ERR_SHORT_KLEN = 3'd1;
  localparam logic [2:0] ERR_SHORT_KEY  = 3'd2;
  localparam logic [2:0] ERR_SHORT_VLEN = 3'd3;
  localparam logic [2:0] ERR_SHORT_VAL  = 3'd4;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic [31:0] field_length;
    logic        record_last;
    logic [2:0]  error_code;
  } out_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/log_record_deframer_core.sv
// Top level of the log record deframer: handshake, parser and result register.
// A word that yields a result shows it on out_valid in the cycle after acceptance.
// Throughput: one input word per cycle while in_ready is high; the parser updates its state in a single pass.
// A word is taken whenever the result register is empty or is being drained that cycle.
// Reset (rst_n low, synchronous) returns the parser to the op phase and empties the output.
`default_nettype none

module log_record_deframer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lrd_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lrd_pkg::out_word_t      out_data
);
  import lrd_pkg::*;

  logic      take;
  logic      res_valid;
  out_word_t res_word;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  lrd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_word   (in_data),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  lrd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res_valid),
    .load_word (res_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/lrd_parse.sv
// Record parser: phase state, length assembly and per-word result decode.
`default_nettype none

module lrd_parse (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire lrd_pkg::in_word_t in_word,
  output logic                   res_valid,
  output lrd_pkg::out_word_t     res_word
);
  import lrd_pkg::*;

  typedef enum logic [2:0] {
    PH_OP   = 3'd0,
    PH_KLEN = 3'd1,
    PH_KEY  = 3'd2,
    PH_VLEN = 3'd3,
    PH_VAL  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] acc_or;
  logic        len_done;

  assign acc_or   = acc_r | ({24'd0, in_word.data_byte} << {cnt_r, 3'b000});
  assign len_done = (cnt_r == 2'd3);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res_word  = '0;
    if (in_word.action == ACT_EOS) begin
      res_valid      = 1'b1;
      res_word.kind  = KIND_ERR;
      case (phase_r)
        PH_KLEN: res_word.error_code = ERR_SHORT_KLEN;
        PH_KEY:  res_word.error_code = ERR_SHORT_KEY;
        PH_VLEN: res_word.error_code = ERR_SHORT_VLEN;
        PH_VAL:  res_word.error_code = ERR_SHORT_VAL;
        default: res_word.error_code = ERR_NO_OP;
      endcase
      phase_nxt = PH_OP;
      cnt_nxt   = 2'd0;
      acc_nxt   = '0;
      rem_nxt   = '0;
    end else begin
      case (phase_r)
        PH_KLEN, PH_VLEN: begin
          acc_nxt = acc_or;
          cnt_nxt = cnt_r + 2'd1;
          if (len_done) begin
            res_valid             = 1'b1;
            res_word.kind         = (phase_r == PH_KLEN) ? KIND_KLEN : KIND_VLEN;
            res_word.field_length = acc_or;
            cnt_nxt               = 2'd0;
            if (acc_or == 32'd0) begin
              res_word.record_last = (phase_r == PH_VLEN);
              phase_nxt = (phase_r == PH_KLEN) ? PH_VLEN : PH_OP;
              acc_nxt   = '0;
              rem_nxt   = '0;
            end else begin
              phase_nxt = (phase_r == PH_KLEN) ? PH_KEY : PH_VAL;
              rem_nxt   = acc_or;
            end
          end
        end
        PH_KEY, PH_VAL: begin
          res_valid         = 1'b1;
          res_word.kind     = (phase_r == PH_KEY) ? KIND_KEY : KIND_VAL;
          res_word.byte_out = in_word.data_byte;
          rem_nxt           = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            res_word.record_last = (phase_r == PH_VAL);
            phase_nxt = (phase_r == PH_KEY) ? PH_VLEN : PH_OP;
            cnt_nxt   = 2'd0;
            acc_nxt   = '0;
            rem_nxt   = '0;
          end
        end
        default: begin
          res_valid         = 1'b1;
          res_word.kind     = KIND_OP;
          res_word.byte_out = in_word.data_byte;
          phase_nxt         = PH_KLEN;
          cnt_nxt           = 2'd0;
          acc_nxt           = '0;
          rem_nxt           = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OP;
      cnt_r   <= 2'd0;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

  a_last_returns_to_op: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_valid && res_word.record_last) |=> (phase_r == PH_OP))
    else $error("record_last word did not return the parser to the op phase");

  a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_KEY || phase_r == PH_VAL) |-> (rem_r != 32'd0))
    else $error("key or value phase entered with no bytes remaining");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_word.action == ACT_EOS) |=> (phase_r == PH_OP && cnt_r == 2'd0))
    else $error("end of stream did not clear the parser state");

endmodule

`default_nettype wire

// File: hw/rtl/lrd_out_reg.sv
// Result register holding one word until the downstream side takes it.
`default_nettype none

module lrd_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire lrd_pkg::out_word_t load_word,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output lrd_pkg::out_word_t      out_data
);
  import lrd_pkg::*;

  logic      valid_r, valid_nxt;
  out_word_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_word;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire
